[design/srb_pkg.sv]
// Shared types, widths and helpers of the segment reorder buffer.
`default_nettype none

package srb_pkg;

    localparam int SEQ_W    = 32;
    localparam int SIZE_W   = 11;
    localparam int HANDLE_W = 8;
    localparam int KIND_W   = 2;

    localparam int SLOTS_DEF       = 16;
    localparam int MAX_SEGMENT_DEF = 1024;
    localparam int HANDLE_BITS_DEF = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_RELEASED = 2'd0,
        KIND_BUFFERED = 2'd1,
        KIND_STALE    = 2'd2,
        KIND_FULL     = 2'd3
    } status_kind_t;

    // One stored early segment.
    typedef struct packed {
        logic [SEQ_W-1:0]    start;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } slot_entry_t;

    // One result as it travels to the output register.
    typedef struct packed {
        status_kind_t        kind;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
    } result_t;

    // True when a lies before b in modulo 2^32 sequence space.
    function automatic logic seq_precedes(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] diff;
        diff = a - b;
        return diff[SEQ_W-1];
    endfunction

endpackage

`default_nettype wire

[design/srb_if.sv]
// Valid/ready channel interfaces for segments in and results out.
`default_nettype none

interface srb_seg_if
    import srb_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [SEQ_W-1:0]    segment_seq;
    logic [SIZE_W-1:0]   segment_size;
    logic [HANDLE_W-1:0] buffer_handle;

    modport source (output valid, output segment_seq, output segment_size,
                    output buffer_handle, input ready);
    modport sink (input valid, input segment_seq, input segment_size,
                  input buffer_handle, output ready);
endinterface

interface srb_res_if
    import srb_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   status_kind;
    logic [SEQ_W-1:0]    out_seq;
    logic [HANDLE_W-1:0] out_handle;
    logic [SIZE_W-1:0]   out_size;
    logic                run_last;

    modport source (output valid, output status_kind, output out_seq,
                    output out_handle, output out_size, output run_last,
                    input ready);
    modport sink (input valid, input status_kind, input out_seq,
                  input out_handle, input out_size, input run_last,
                  output ready);
endinterface

`default_nettype wire

[design/srb_slot_mem.sv]
// Slot store: one write port, one read port with registered read data.
`default_nettype none

module srb_slot_mem
    import srb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr,
    input  wire slot_entry_t                                wdata,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
    output      slot_entry_t                                rdata
);

    slot_entry_t mem_q [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem_q[raddr];
    end

endmodule

`default_nettype wire

[design/srb_ctrl.sv]
// Sequencer: expected number, slot valid bits, store walks and result register.
`default_nettype none

module srb_ctrl
    import srb_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int MAX_SEGMENT = MAX_SEGMENT_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    srb_seg_if.sink                                         segment,
    srb_res_if.source                                       result,
    input  wire logic                                       cfg_we,
    input  wire logic [SEQ_W-1:0]                           cfg_wdata,
    output      logic                                       mem_we,
    output      logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] mem_waddr,
    output      slot_entry_t                                mem_wdata,
    output      logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] mem_raddr,
    input  wire slot_entry_t                                mem_rdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(SLOTS);
    localparam logic [SIZE_W-1:0] SIZE_CAP =
        (MAX_SEGMENT >= (1 << SIZE_W) - 1) ? {SIZE_W{1'b1}} : SIZE_W'(MAX_SEGMENT);
    localparam logic [HANDLE_W-1:0] HANDLE_MASK =
        (HANDLE_BITS >= HANDLE_W) ? {HANDLE_W{1'b1}} : HANDLE_W'((1 << HANDLE_BITS) - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REL,
        S_INS,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [SEQ_W-1:0]    expected_reg, expected_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]    miss_cnt_reg, miss_cnt_next;
    logic                dup_reg, dup_next;
    result_t             pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;
    logic                out_last_reg, out_last_next;

    logic [SIZE_W-1:0]   in_size;
    logic [HANDLE_W-1:0] in_handle;
    logic                out_free;
    logic                entry_valid;
    logic                hit;
    logic                stranded;
    logic                dup_all;
    logic [IDX_W-1:0]    scan_wrap;
    logic [CNT_W-1:0]    miss_inc;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;

    assign in_size   = (segment.segment_size > SIZE_CAP) ? SIZE_CAP : segment.segment_size;
    assign in_handle = segment.buffer_handle & HANDLE_MASK;
    assign out_free  = !out_valid_reg || result.ready;

    assign entry_valid = valid_reg[scan_idx_reg];
    assign hit         = entry_valid && (mem_rdata.start == expected_reg);
    assign stranded    = entry_valid && seq_precedes(mem_rdata.start, expected_reg);
    assign dup_all     = dup_reg || (entry_valid && (mem_rdata.start == pend_reg.seq));
    assign scan_wrap   = (scan_idx_reg == LAST_IDX) ? '0 : scan_idx_reg + 1'b1;
    assign miss_inc    = miss_cnt_reg + 1'b1;

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign segment.ready      = (state_reg == S_IDLE) && !cfg_we;
    assign result.valid       = out_valid_reg;
    assign result.status_kind = out_reg.kind;
    assign result.out_seq     = out_reg.seq;
    assign result.out_handle  = out_reg.handle;
    assign result.out_size    = out_reg.size;
    assign result.run_last    = out_last_reg;

    assign mem_waddr = free_idx;
    assign mem_wdata = '{start: pend_reg.seq, size: pend_reg.size, handle: pend_reg.handle};

    always_comb
    begin
        state_next     = state_reg;
        expected_next  = expected_reg;
        valid_next     = valid_reg;
        scan_idx_next  = scan_idx_reg;
        miss_cnt_next  = miss_cnt_reg;
        dup_next       = dup_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_raddr      = scan_idx_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    expected_next = cfg_wdata;
                    valid_next    = '0;
                end
                else if (segment.valid)
                begin
                    pend_next     = '{kind: KIND_RELEASED, seq: segment.segment_seq,
                                      handle: in_handle, size: in_size};
                    scan_idx_next = '0;
                    mem_raddr     = '0;
                    miss_cnt_next = '0;
                    dup_next      = 1'b0;
                    if (segment.segment_seq == expected_reg)
                    begin
                        expected_next = segment.segment_seq + SEQ_W'(in_size);
                        state_next    = S_REL;
                    end
                    else if (seq_precedes(segment.segment_seq, expected_reg))
                    begin
                        pend_next.kind = KIND_STALE;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        pend_next.kind = KIND_BUFFERED;
                        state_next     = S_INS;
                    end
                end
            end

            S_REL:
            begin
                if (hit)
                begin
                    // Push the held release and hold this one until the walk ends.
                    if (out_free)
                    begin
                        out_valid_next          = 1'b1;
                        out_next                = pend_reg;
                        out_last_next           = 1'b0;
                        pend_next               = '{kind: KIND_RELEASED,
                                                    seq: mem_rdata.start,
                                                    handle: mem_rdata.handle,
                                                    size: mem_rdata.size};
                        expected_next           = mem_rdata.start + SEQ_W'(mem_rdata.size);
                        valid_next[scan_idx_reg] = 1'b0;
                        miss_cnt_next           = '0;
                        scan_idx_next           = scan_wrap;
                        mem_raddr               = scan_wrap;
                    end
                end
                else
                begin
                    if (stranded)
                    begin
                        valid_next[scan_idx_reg] = 1'b0;
                    end
                    scan_idx_next = scan_wrap;
                    mem_raddr     = scan_wrap;
                    miss_cnt_next = miss_inc;
                    if (miss_inc == SLOT_COUNT)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_INS:
            begin
                dup_next      = dup_all;
                scan_idx_next = scan_wrap;
                mem_raddr     = scan_wrap;
                miss_cnt_next = miss_inc;
                if (miss_inc == SLOT_COUNT)
                begin
                    state_next = S_EMIT;
                    if (dup_all)
                    begin
                        pend_next.kind = KIND_STALE;
                    end
                    else if (!free_found)
                    begin
                        pend_next.kind = KIND_FULL;
                    end
                    else
                    begin
                        mem_we               = 1'b1;
                        valid_next[free_idx] = 1'b1;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            expected_reg  <= '0;
            valid_reg     <= '0;
            scan_idx_reg  <= '0;
            miss_cnt_reg  <= '0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            valid_reg     <= valid_next;
            scan_idx_reg  <= scan_idx_next;
            miss_cnt_reg  <= miss_cnt_next;
            dup_reg       <= dup_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

[design/segment_reorder_buffer.sv]
// Top level of the segment reorder buffer: slot store plus walking sequencer.
// Stale drop: the sequencer goes straight to the emit state, loads the result register once it is free
// and returns to idle. Buffer, duplicate or full drop: the store is walked, then the result emitted;
// the single read port walks one slot a cycle. A release run walks on until a full pass finds no
// hit, and pauses on a hit while the result register is full; no new transfer is taken until idle.
// Reset clears the control state: expected number zero, every slot free, no clearing pass.
`default_nettype none

module segment_reorder_buffer
    import srb_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int MAX_SEGMENT = MAX_SEGMENT_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    srb_seg_if.sink               segment,
    srb_res_if.source             result,
    input  wire logic             cfg_we,
    input  wire logic [SEQ_W-1:0] cfg_wdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Slot store port: one write at insert time, one read a cycle during a walk.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_entry_t      mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    slot_entry_t      mem_rdata;

    // Sequencer: accepts a segment transfer only when idle, walks the store and
    // drives the result register. A configuration write while idle loads the expected
    // number and frees every slot in the same cycle; one while busy is ignored.
    srb_ctrl #(
        .SLOTS       (SLOTS),
        .MAX_SEGMENT (MAX_SEGMENT),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .segment   (segment),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Early segments: start, saturated length and handle of each slot.
    srb_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

`ifndef NO_ASSERTIONS
    // The store is written only while a segment is being handled.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !segment.ready)
        else $error("slot store written while idle");

    // At most one store write per segment.
    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> !mem_we)
        else $error("slot store written twice in a row");

    // A transfer in always leaves the idle state.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        segment.valid && segment.ready |=> !segment.ready)
        else $error("ready held after a segment transfer");

    // Only release runs carry more than one result.
    a_run_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.run_last |-> result.status_kind == KIND_RELEASED)
        else $error("status result not marked last");
`endif

endmodule

`default_nettype wire
